### sv/tgarle_pkg.sv
// Shared types, constants and helpers for the TGA RLE pixel decoder.
// No dependencies; every other file refers to it by scoped names.
package tgarle_pkg;

	// Width of the column counter and of the used part of row_width
	localparam int WIDTH_BITS = 16;

	// Effective row width, one bit wider so that a zero setting can mean a full row
	localparam logic [WIDTH_BITS:0] ROW_FULL = {1'b1, {WIDTH_BITS{1'b0}}};

	// pixel_mode codes
	localparam logic [1:0] MODE_GRAY8  = 2'd0;
	localparam logic [1:0] MODE_RGB555 = 2'd1;
	localparam logic [1:0] MODE_BGR24  = 2'd2;
	localparam logic [1:0] MODE_BGRA32 = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_PIXEL_MODE = 2'd0;
	localparam logic [1:0] CFG_RLE_ENABLE = 2'd1;
	localparam logic [1:0] CFG_ROW_WIDTH  = 2'd2;

	localparam logic [7:0] HDR_RUN_MASK   = 8'h80;
	localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} colour_t;

	// Widen a 5-bit colour field to 8 bits by repeating its top bits
	function automatic logic [7:0] widen5(input logic [4:0] v);
		widen5 = {v, v[4:2]};
	endfunction

endpackage

### sv/tga_rle_pixel_decoder_unit.sv
// Top level of the TGA RLE pixel decoder: byte parser, packet and row tracking.
// Depends on tgarle_pkg and tgarle_pixel_fmt.
//
// Usage:
//   Input channel (in_valid / in_stall / data_byte) takes one beat per byte of
//   TGA pixel data. Output channel (out_valid / out_stall and the colour,
//   repeat_count, row_end and overflow ports) gives one beat per completed
//   pixel; header bytes, incomplete pixels and clipped excess literal pixels
//   give none.
//   Pipeline: a byte is held in the input register, then the parser
//   updates its counters and loads the result register, which puts the
//   pixel completed by that byte on the output.
//   Throughput: one byte per cycle, sustained, while the receiver takes beats;
//   the parser step between input and result register sets it.
//   Stall: while out_stall holds a result, the input register holds its byte
//   and in_stall rises once it is full; no beat is lost or repeated.
//   Reset (arst_n low): registers return to pixel_mode 0, rle_enable 0,
//   row_width 1, header expected, all counters clear, both channels empty.
//   Configuration: cfg_wr_en writes register cfg_index with cfg_data; write
//   only while the block is idle. Index 3 is ignored. A row_width of zero
//   means a row of 2^WIDTH_BITS pixels.
module tga_rle_pixel_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [7:0]  repeat_count,
	output logic        row_end,
	output logic        overflow
);

	localparam int CW = tgarle_pkg::WIDTH_BITS;

	// configuration
	logic [1:0]    pixel_mode_q;
	logic          rle_enable_q;
	logic [15:0]   row_width_q;

	// parser state
	logic          expect_header_q;
	logic          packet_is_run_q;
	logic [7:0]    packet_left_q;
	logic [6:0]    packet_skip_q;
	logic          packet_clipped_q;
	logic [1:0]    byte_index_q;
	logic [23:0]   pixel_bytes_q;
	logic [CW-1:0] column_count_q;

	// input register
	logic          valid_s1;
	logic [7:0]    data_s1;

	// result register
	logic          valid_s2;
	tgarle_pkg::colour_t colour_s2;
	logic [7:0]    repeat_s2;
	logic          row_end_s2;
	logic          overflow_s2;

	// next-state values from the parser
	logic          expect_header_d;
	logic          packet_is_run_d;
	logic [7:0]    packet_left_d;
	logic [6:0]    packet_skip_d;
	logic          packet_clipped_d;
	logic [1:0]    byte_index_d;
	logic [23:0]   pixel_bytes_d;
	logic [CW-1:0] column_count_d;
	logic          fire;
	logic [7:0]    rep;
	logic          row_end_c;
	logic          overflow_c;

	logic          out_free;
	logic          step;
	logic [CW-1:0] row_width_m;
	logic [CW:0]   eff_width;
	logic [CW:0]   column_ext;
	logic [CW:0]   room;
	logic [7:0]    count;
	logic [7:0]    kept;
	logic          header;
	logic [CW:0]   column_sum;
	logic [6:0]    skip_dec;
	tgarle_pkg::colour_t colour_c;

	// result register can take a new beat when empty or being drained
	assign out_free = !valid_s2 || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	assign row_width_m = row_width_q[CW-1:0];
	assign eff_width   = (row_width_m == '0) ? tgarle_pkg::ROW_FULL : {1'b0, row_width_m};
	assign column_ext  = {1'b0, column_count_q};
	// a column past the row end leaves room for one pixel
	assign room        = (column_ext < eff_width) ? (eff_width - column_ext) : (CW+1)'(1);

	assign count  = {1'b0, data_s1[6:0] & tgarle_pkg::HDR_COUNT_MASK[6:0]} + 8'd1;
	assign kept   = ({{(CW-7){1'b0}}, count} > room) ? room[7:0] : count;
	assign header = rle_enable_q &&
		(expect_header_q || (packet_left_q == 8'd0 && packet_skip_q == 7'd0));
	assign skip_dec = packet_skip_q - 7'd1;
	assign column_sum = column_ext + {{(CW-7){1'b0}}, rep};

	tgarle_pixel_fmt u_fmt (
		.pixel_mode  (pixel_mode_q),
		.pixel_bytes (pixel_bytes_q),
		.last_byte   (data_s1),
		.colour      (colour_c)
	);

	always_comb begin
		expect_header_d  = expect_header_q;
		packet_is_run_d  = packet_is_run_q;
		packet_left_d    = packet_left_q;
		packet_skip_d    = packet_skip_q;
		packet_clipped_d = packet_clipped_q;
		byte_index_d     = byte_index_q;
		pixel_bytes_d    = pixel_bytes_q;
		column_count_d   = column_count_q;
		fire             = 1'b0;
		rep              = 8'd1;
		row_end_c        = 1'b0;
		overflow_c       = 1'b0;

		if (rle_enable_q && packet_is_run_q && !header) begin
			rep = packet_left_q;
		end

		if (header) begin
			// open a packet, clipped to the room left in the row
			packet_is_run_d  = (data_s1 & tgarle_pkg::HDR_RUN_MASK) != 8'd0;
			packet_left_d    = kept;
			packet_skip_d    = packet_is_run_d ? 7'd0 : 7'(count - kept);
			packet_clipped_d = {{(CW-7){1'b0}}, count} > room;
			expect_header_d  = 1'b0;
			byte_index_d     = 2'd0;
			pixel_bytes_d    = 24'd0;
		end else if (byte_index_q < pixel_mode_q) begin
			// gather a low byte of the pixel
			case (byte_index_q)
				2'd0: pixel_bytes_d[7:0]   = pixel_bytes_q[7:0]   | data_s1;
				2'd1: pixel_bytes_d[15:8]  = pixel_bytes_q[15:8]  | data_s1;
				2'd2: pixel_bytes_d[23:16] = pixel_bytes_q[23:16] | data_s1;
				default: pixel_bytes_d = pixel_bytes_q;
			endcase
			byte_index_d = byte_index_q + 2'd1;
		end else begin
			byte_index_d  = 2'd0;
			pixel_bytes_d = 24'd0;
			if (rle_enable_q && packet_left_q == 8'd0) begin
				// drop an excess literal pixel of a clipped packet
				packet_skip_d = skip_dec;
				if (skip_dec == 7'd0) begin
					expect_header_d = 1'b1;
				end
			end else begin
				fire = 1'b1;
				if (rle_enable_q) begin
					if (packet_is_run_q) begin
						packet_left_d = 8'd0;
					end else begin
						packet_left_d = packet_left_q - 8'd1;
					end
				end
				row_end_c = column_sum >= eff_width;
				if (row_end_c) begin
					column_count_d = '0;
					overflow_c     = rle_enable_q && packet_clipped_q;
				end else begin
					column_count_d = column_sum[CW-1:0];
				end
				if (rle_enable_q && packet_left_d == 8'd0 && packet_skip_q == 7'd0) begin
					expect_header_d = 1'b1;
				end
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= tgarle_pkg::MODE_GRAY8;
			rle_enable_q <= 1'b0;
			row_width_q  <= 16'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tgarle_pkg::CFG_PIXEL_MODE: pixel_mode_q <= cfg_data[1:0];
				tgarle_pkg::CFG_RLE_ENABLE: rle_enable_q <= cfg_data[0];
				tgarle_pkg::CFG_ROW_WIDTH:  row_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// parser state advances once per byte leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q  <= 1'b1;
			packet_is_run_q  <= 1'b0;
			packet_left_q    <= 8'd0;
			packet_skip_q    <= 7'd0;
			packet_clipped_q <= 1'b0;
			byte_index_q     <= 2'd0;
			pixel_bytes_q    <= 24'd0;
			column_count_q   <= '0;
		end else if (step) begin
			expect_header_q  <= expect_header_d;
			packet_is_run_q  <= packet_is_run_d;
			packet_left_q    <= packet_left_d;
			packet_skip_q    <= packet_skip_d;
			packet_clipped_q <= packet_clipped_d;
			byte_index_q     <= byte_index_d;
			pixel_bytes_q    <= pixel_bytes_d;
			column_count_q   <= column_count_d;
		end
	end

	// input register: load on accept, empty when the parser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
		end
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (step && fire) begin
			colour_s2   <= colour_c;
			repeat_s2   <= rep;
			row_end_s2  <= row_end_c;
			overflow_s2 <= overflow_c;
		end
	end

	assign out_valid    = valid_s2;
	assign red          = colour_s2.red;
	assign green        = colour_s2.green;
	assign blue         = colour_s2.blue;
	assign alpha        = colour_s2.alpha;
	assign repeat_count = repeat_s2;
	assign row_end      = row_end_s2;
	assign overflow     = overflow_s2;

endmodule

### sv/tgarle_pixel_fmt.sv
// Colour assembly for one completed pixel at the configured depth.
// Depends on tgarle_pkg for the mode codes, colour_t and widen5.
module tgarle_pixel_fmt (
	input  logic [1:0]               pixel_mode,
	input  logic [23:0]              pixel_bytes,
	input  logic [7:0]               last_byte,
	output tgarle_pkg::colour_t      colour
);

	logic [15:0] word16;

	assign word16 = {last_byte, pixel_bytes[7:0]};

	always_comb begin
		case (pixel_mode)
			tgarle_pkg::MODE_GRAY8: begin
				colour.red   = last_byte;
				colour.green = last_byte;
				colour.blue  = last_byte;
				colour.alpha = tgarle_pkg::ALPHA_OPAQUE;
			end
			tgarle_pkg::MODE_RGB555: begin
				// bit 15 is ignored
				colour.red   = tgarle_pkg::widen5(word16[14:10]);
				colour.green = tgarle_pkg::widen5(word16[9:5]);
				colour.blue  = tgarle_pkg::widen5(word16[4:0]);
				colour.alpha = tgarle_pkg::ALPHA_OPAQUE;
			end
			tgarle_pkg::MODE_BGR24: begin
				colour.blue  = pixel_bytes[7:0];
				colour.green = pixel_bytes[15:8];
				colour.red   = last_byte;
				colour.alpha = tgarle_pkg::ALPHA_OPAQUE;
			end
			default: begin
				colour.blue  = pixel_bytes[7:0];
				colour.green = pixel_bytes[15:8];
				colour.red   = pixel_bytes[23:16];
				colour.alpha = last_byte;
			end
		endcase
	end

endmodule

### bench/tb_top.sv
// Self-checking bench for the TGA RLE pixel decoder: directed script, then random phases.
// Depends on tgarle_pkg and tga_rle_pixel_decoder_unit; predicts every pixel beat in-house.
module tb_top;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 12;
	// a header or a partial pixel may still sit in the pipe when the last pixel has left
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASES       = 10;
	localparam int PHASE_BYTES  = 60;
	localparam int HOLD_AT      = 320;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_CAP    = 50;

	// unused register slot; the block must ignore writes to it
	localparam logic [1:0] CFG_SPARE = 2'd3;

	// one pixel beat as it leaves the block
	typedef struct packed {
		tgarle_pkg::colour_t colour;
		logic [7:0] rep;
		logic       row_end;
		logic       ovf;
	} pixel_t;

	typedef enum logic {STEP_BYTE, STEP_REG} step_kind_t;

	// one row of the directed script
	typedef struct packed {
		step_kind_t  kind;
		logic [1:0]  idx;
		logic [15:0] val;
		logic        typed;
		pixel_t      want;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  red, green, blue, alpha, repeat_count;
	logic        row_end;
	logic        overflow;

	tga_rle_pixel_decoder_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.repeat_count (repeat_count),
		.row_end      (row_end),
		.overflow     (overflow)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Register copies, as the block holds them after reset
	logic [1:0]  cur_mode  = tgarle_pkg::MODE_GRAY8;
	bit          cur_rle   = 1'b0;
	logic [15:0] cur_width = 16'd1;

	// Decoder state: packet tracking, pixel assembly and column position
	bit          want_header = 1'b1;
	bit          in_run      = 1'b0;
	int          pkt_left    = 0;
	int          pkt_skip    = 0;   // literal pixels cut off by clipping, eaten silently
	bit          pkt_clipped = 1'b0;
	int          byte_pos    = 0;
	logic [23:0] partial     = '0;
	int          column      = 0;

	pixel_t pending_pixels[$];
	step_t  script[$];
	int     mismatch_count = 0;
	int     bytes_sent     = 0;
	int     cycle_count    = 0;
	bit     tx_burst       = 1'b0;
	bit     hold_off       = 1'b0;

	function automatic logic [7:0] spread5(input logic [4:0] f);
		return ({3'b000, f} << 3) | ({3'b000, f} >> 2);
	endfunction

	function automatic void set_reg(input logic [1:0] idx, input logic [15:0] val);
		case (idx)
			tgarle_pkg::CFG_PIXEL_MODE: cur_mode  = val[1:0];
			tgarle_pkg::CFG_RLE_ENABLE: cur_rle   = val[0];
			tgarle_pkg::CFG_ROW_WIDTH:  cur_width = val;
			default: ;
		endcase
	endfunction

	// Advance the decoder state by one byte; return 1 with the pixel when one leaves
	function automatic bit decode_byte(input logic [7:0] b, output pixel_t px);
		int         nbytes, count, room, kept, full, span, rep;
		logic [15:0] word;
		logic [7:0]  r, g, bl, a;
		full   = 1 << tgarle_pkg::WIDTH_BITS;
		span   = int'(cur_width) % full;
		if (span == 0)
			span = full;
		nbytes = int'(cur_mode) + 1;
		px     = '0;

		// packet header: open a run or a literal packet, clipped to what is left of the row
		if (cur_rle && (want_header || (pkt_left == 0 && pkt_skip == 0))) begin
			count       = int'(b & tgarle_pkg::HDR_COUNT_MASK) + 1;
			room        = (column < span) ? span - column : 1;
			kept        = (count > room) ? room : count;
			in_run      = (b & tgarle_pkg::HDR_RUN_MASK) != 0;
			pkt_left    = kept;
			pkt_skip    = in_run ? 0 : count - kept;
			pkt_clipped = count > room;
			want_header = 1'b0;
			byte_pos    = 0;
			partial     = '0;
			return 1'b0;
		end

		// collect the low bytes of a pixel, low byte first
		if (byte_pos + 1 < nbytes) begin
			partial  = partial | (24'(b) << (8 * byte_pos));
			byte_pos = (byte_pos + 1) % 4;
			return 1'b0;
		end

		a = tgarle_pkg::ALPHA_OPAQUE;
		case (cur_mode)
			tgarle_pkg::MODE_GRAY8: begin
				r  = b;
				g  = b;
				bl = b;
			end
			tgarle_pkg::MODE_RGB555: begin
				word = {b, partial[7:0]};
				r    = spread5(word[14:10]);
				g    = spread5(word[9:5]);
				bl   = spread5(word[4:0]);
			end
			tgarle_pkg::MODE_BGR24: begin
				bl = partial[7:0];
				g  = partial[15:8];
				r  = b;
			end
			default: begin
				bl = partial[7:0];
				g  = partial[15:8];
				r  = partial[23:16];
				a  = b;
			end
		endcase
		byte_pos = 0;
		partial  = '0;

		// pixel beyond the row end of a clipped literal packet: drop it
		if (cur_rle && pkt_left == 0) begin
			pkt_skip--;
			if (pkt_skip == 0)
				want_header = 1'b1;
			return 1'b0;
		end

		rep = 1;
		if (cur_rle) begin
			if (in_run) begin
				rep      = pkt_left;
				pkt_left = 0;
			end else begin
				pkt_left--;
			end
		end

		px.colour  = {r, g, bl, a};
		px.rep     = 8'(rep);
		px.row_end = (column + rep >= span);
		if (px.row_end) begin
			column = 0;
			px.ovf = cur_rle && pkt_clipped;
		end else begin
			column = (column + rep) % full;
		end
		if (cur_rle && pkt_left == 0 && pkt_skip == 0)
			want_header = 1'b1;
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			flag_mismatch(name, int'(got), int'(want));
	endtask

	task automatic add_byte(input logic [7:0] b);
		step_t s;
		s       = '0;
		s.kind  = STEP_BYTE;
		s.val   = {8'h00, b};
		script.push_back(s);
	endtask

	// byte whose pixel can be read off directly: grey shade, opaque
	task automatic add_gray(input logic [7:0] b, input logic [7:0] shade, input logic [7:0] rep,
			input logic rend, input logic ovf);
		step_t s;
		s       = '0;
		s.kind  = STEP_BYTE;
		s.val   = {8'h00, b};
		s.typed = 1'b1;
		s.want  = {shade, shade, shade, tgarle_pkg::ALPHA_OPAQUE, rep, rend, ovf};
		script.push_back(s);
	endtask

	task automatic add_reg(input logic [1:0] idx, input logic [15:0] val);
		step_t s;
		s      = '0;
		s.kind = STEP_REG;
		s.idx  = idx;
		s.val  = val;
		script.push_back(s);
	endtask

	// Offer one byte beat after a random gap; predict once it is taken
	task automatic offer_byte(input logic [7:0] b, input bit typed, input pixel_t want);
		int     gap;
		pixel_t px;
		bit     made;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		made = decode_byte(b, px);
		if (typed)
			pending_pixels.push_back(want);
		else if (made)
			pending_pixels.push_back(px);
		bytes_sent++;
	endtask

	// Drop the input, let the block go quiet, then write a register and mirror it
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		set_reg(idx, val);
	endtask

	// One setting per phase, partly fixed in the early phases, then mostly well-formed packets with random content
	task automatic run_phase(input int p);
		logic [1:0]  mode;
		bit          rle;
		bit          is_run;
		logic [15:0] width;
		int          sent, len, npix;
		mode = (p == 0) ? tgarle_pkg::MODE_GRAY8 :
			(p == 1) ? tgarle_pkg::MODE_BGRA32 : 2'($urandom_range(0, 3));
		rle  = (p == 2 || p == 5) ? 1'b0 : ($urandom_range(0, 4) != 0);
		case (p)
			0: width = 16'd1;
			1: width = 16'hFFFF;
			2: width = 16'd0;
			default: begin
				if ($urandom_range(0, 5) == 0)
					width = 16'($urandom_range(1, 65535));
				else
					width = 16'($urandom_range(1, 24));
			end
		endcase
		// upper bits of the narrow registers carry junk the block must drop
		write_reg(tgarle_pkg::CFG_PIXEL_MODE, {14'($urandom), mode});
		write_reg(tgarle_pkg::CFG_RLE_ENABLE, {15'($urandom), rle});
		write_reg(tgarle_pkg::CFG_ROW_WIDTH, width);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_SPARE, 16'($urandom));

		sent = 0;
		while (sent < PHASE_BYTES) begin
			if (rle && $urandom_range(0, 99) < 85) begin
				is_run = 1'($urandom_range(0, 1));
				if (is_run)
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 127)
						: $urandom_range(0, 7);
				else
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 31)
						: $urandom_range(0, 7);
				offer_byte({is_run, 7'(len)}, 1'b0, '0);
				sent++;
				npix = is_run ? 1 : len + 1;
				repeat (npix * (int'(cur_mode) + 1)) begin
					offer_byte(8'($urandom), 1'b0, '0);
					sent++;
				end
			end else begin
				// noise: stray bytes that break packet alignment
				repeat ($urandom_range(1, 3)) begin
					offer_byte(8'($urandom), 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	// Receiver: random stall before each beat, with the long hold-off on top
	initial begin : receiver
		int  gap;
		bit  rx_burst;
		rx_burst  = 1'b0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			gap = rx_burst ? 0 : $urandom_range(0, 19);
			repeat (gap) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			while (hold_off) begin
				out_stall <= 1'b1;
				@(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Hold the output off for a long stretch so the block fills and stalls its input
	initial begin : pressure
		wait (bytes_sent >= HOLD_AT);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Compare each pixel beat with the oldest prediction
	always @(posedge clk) begin : check_beats
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				flag_mismatch("pixel beat with none pending", int'(red), 0);
			end else begin
				want = pending_pixels.pop_front();
				check_field("red", red, want.colour.red);
				check_field("green", green, want.colour.green);
				check_field("blue", blue, want.colour.blue);
				check_field("alpha", alpha, want.colour.alpha);
				check_field("repeat_count", repeat_count, want.rep);
				check_field("row_end", {7'd0, row_end}, {7'd0, want.row_end});
				check_field("overflow", {7'd0, overflow}, {7'd0, want.ovf});
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int guard;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = tgarle_pkg::CFG_PIXEL_MODE;
		cfg_data  = '0;
		in_valid  = 1'b0;
		data_byte = '0;

		// After reset: grey, raw, one-pixel rows, so every pixel ends its row
		add_gray(8'h00, 8'h00, 8'd1, 1'b1, 1'b0);
		add_reg(CFG_SPARE, 16'hFFFF);
		add_gray(8'hFF, 8'hFF, 8'd1, 1'b1, 1'b0);
		// 5:5:5 with bit 15 set: every field at full scale
		add_reg(tgarle_pkg::CFG_PIXEL_MODE, {14'd0, tgarle_pkg::MODE_RGB555});
		add_byte(8'hFF);
		add_gray(8'hFF, 8'hFF, 8'd1, 1'b1, 1'b0);
		add_byte(8'h1F);
		add_byte(8'h7C);
		add_reg(tgarle_pkg::CFG_PIXEL_MODE, {14'd0, tgarle_pkg::MODE_BGR24});
		add_byte(8'h11);
		add_byte(8'h22);
		add_byte(8'h33);
		add_reg(tgarle_pkg::CFG_PIXEL_MODE, {14'd0, tgarle_pkg::MODE_BGRA32});
		add_byte(8'h01);
		add_byte(8'h02);
		add_byte(8'h03);
		add_byte(8'h04);
		// depth drops mid-pixel: the next byte completes it
		add_byte(8'hC3);
		add_byte(8'h5A);
		add_reg(tgarle_pkg::CFG_PIXEL_MODE, {14'd0, tgarle_pkg::MODE_RGB555});
		add_byte(8'h3C);
		// run of six into a four-pixel row: clipped to four, overflow set
		add_reg(tgarle_pkg::CFG_RLE_ENABLE, 16'd1);
		add_reg(tgarle_pkg::CFG_ROW_WIDTH, 16'd4);
		add_reg(tgarle_pkg::CFG_PIXEL_MODE, {14'd0, tgarle_pkg::MODE_GRAY8});
		add_byte(8'h85);
		add_gray(8'h77, 8'h77, 8'd4, 1'b1, 1'b1);
		// five literals into a three-pixel row: last kept one flags overflow, two dropped
		add_reg(tgarle_pkg::CFG_ROW_WIDTH, 16'd3);
		add_byte(8'h04);
		add_byte(8'h10);
		add_byte(8'h20);
		add_gray(8'h30, 8'h30, 8'd1, 1'b1, 1'b1);
		add_byte(8'h40);
		add_byte(8'h50);
		add_byte(8'h00);
		add_byte(8'h60);
		// zero width means a full-size row: a run of 128 stays inside it
		add_reg(tgarle_pkg::CFG_ROW_WIDTH, 16'd0);
		add_byte(8'hFF);
		add_gray(8'h9C, 8'h9C, 8'd128, 1'b0, 1'b0);
		// shrink the row below the current column: the next pixel ends the row
		add_reg(tgarle_pkg::CFG_ROW_WIDTH, 16'd5);
		add_byte(8'h00);
		add_byte(8'hE1);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == STEP_REG)
				write_reg(script[i].idx, script[i].val);
			else
				offer_byte(script[i].val[7:0], script[i].typed, script[i].want);
		end

		for (int p = 0; p < PHASES; p++)
			run_phase(p);

		@(negedge clk);
		in_valid <= 1'b0;

		// drain what is still in flight, then allow stray beats to show up
		guard = 0;
		while (pending_pixels.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES * 4) @(posedge clk);
		if (pending_pixels.size() != 0)
			flag_mismatch("pixels never delivered", pending_pixels.size(), 0);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
